// File: src/skvt_pkg.sv
// Shared constants, types and helpers of the sorted key/value table.
package skvt_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OUT_W    = 11;
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   function automatic logic [CNT_W-1:0] idx_to_cnt(input logic [IDX_W-1:0] idx);
      return CNT_W'(idx);
   endfunction

   function automatic logic [OUT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
      return OUT_W'(cnt);
   endfunction

endpackage

// File: src/skvt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module skvt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/skvt_seq.sv
// Sequencer: binary search, hit check, entry shift and result register.
module skvt_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [skvt_pkg::KEY_W-1:0]    req_key,
   input  logic [skvt_pkg::VAL_W-1:0]    req_value,
   output skvt_pkg::ram_req_type         ram_req,
   input  skvt_pkg::entry_type           ram_rd_data,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [skvt_pkg::VAL_W-1:0]    rsp_found_value,
   output logic [skvt_pkg::OUT_W-1:0]    rsp_position,
   output logic [skvt_pkg::OUT_W-1:0]    rsp_entry_count
);

   typedef enum logic [2:0] {
      IDLE,
      SEARCH,
      COMPARE,
      HIT_READ,
      HIT_CHECK,
      SHIFT_UP,
      SHIFT_DOWN
   } state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     cmd_ff, cmd_in;
   logic [skvt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [skvt_pkg::VAL_W-1:0]     value_ff, value_in;
   logic [skvt_pkg::VAL_W-1:0]     found_ff, found_in;
   logic [skvt_pkg::CNT_W-1:0]     occ_ff, occ_in;
   logic [skvt_pkg::CNT_W-1:0]     lo_ff, lo_in;
   logic [skvt_pkg::CNT_W-1:0]     hi_ff, hi_in;
   logic [skvt_pkg::IDX_W-1:0]     mid_ff, mid_in;
   logic [skvt_pkg::CNT_W-1:0]     remain_ff, remain_in;
   logic [skvt_pkg::IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [skvt_pkg::IDX_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                           pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [skvt_pkg::VAL_W-1:0]     rsp_found_ff, rsp_found_in;
   logic [skvt_pkg::OUT_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [skvt_pkg::OUT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [skvt_pkg::CNT_W-1:0]     mid_full;
   logic [skvt_pkg::CNT_W-1:0]     occ_m1;
   logic [skvt_pkg::CNT_W-1:0]     lo_p1;
   logic                           lo_lt_occ;
   logic                           hit;
   logic                           resp_go;
   logic [1:0]                     resp_status;
   logic [skvt_pkg::VAL_W-1:0]     resp_found;
   logic [skvt_pkg::CNT_W-1:0]     resp_count;

   assign mid_full  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign occ_m1    = occ_ff - skvt_pkg::CNT_W'(1);
   assign lo_p1     = lo_ff + skvt_pkg::CNT_W'(1);
   assign lo_lt_occ = (lo_ff < occ_ff);
   assign hit       = lo_lt_occ && (ram_rd_data.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      occ_in       = occ_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      remain_in    = remain_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_addr_in   = wr_addr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      resp_go      = 1'b0;
      resp_status  = skvt_pkg::ST_OK;
      resp_found   = '0;
      resp_count   = occ_ff;
      ram_req      = '0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               key_in   = req_key;
               value_in = req_value;
               lo_in    = '0;
               hi_in    = occ_ff;
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid_full[skvt_pkg::IDX_W-1:0];
               mid_in          = mid_full[skvt_pkg::IDX_W-1:0];
               state_in        = COMPARE;
            end else begin
               state_in = HIT_READ;
            end
         end
         COMPARE: begin
            if (ram_rd_data.key < key_ff) begin
               lo_in = skvt_pkg::idx_to_cnt(mid_ff) + skvt_pkg::CNT_W'(1);
            end else begin
               hi_in = skvt_pkg::idx_to_cnt(mid_ff);
            end
            state_in = SEARCH;
         end
         HIT_READ: begin
            ram_req.rd_en   = lo_lt_occ;
            ram_req.rd_addr = lo_ff[skvt_pkg::IDX_W-1:0];
            state_in        = HIT_CHECK;
         end
         HIT_CHECK: begin
            priority if (cmd_ff == skvt_pkg::CMD_INSERT) begin
               if (hit) begin
                  resp_go     = 1'b1;
                  resp_status = skvt_pkg::ST_PRESENT;
               end else if (occ_ff == skvt_pkg::CNT_W'(skvt_pkg::CAPACITY)) begin
                  resp_go     = 1'b1;
                  resp_status = skvt_pkg::ST_FULL;
               end else begin
                  remain_in = occ_ff - lo_ff;
                  rd_ptr_in = occ_m1[skvt_pkg::IDX_W-1:0];
                  pend_in   = 1'b0;
                  state_in  = SHIFT_UP;
               end
            end else if (cmd_ff == skvt_pkg::CMD_DELETE) begin
               if (hit) begin
                  found_in  = ram_rd_data.value;
                  remain_in = occ_m1 - lo_ff;
                  rd_ptr_in = lo_p1[skvt_pkg::IDX_W-1:0];
                  pend_in   = 1'b0;
                  state_in  = SHIFT_DOWN;
               end else begin
                  resp_go     = 1'b1;
                  resp_status = skvt_pkg::ST_MISSING;
               end
            end else begin
               resp_go = 1'b1;
               if (hit) begin
                  resp_status = skvt_pkg::ST_OK;
                  resp_found  = ram_rd_data.value;
               end else begin
                  resp_status = skvt_pkg::ST_MISSING;
               end
            end
         end
         SHIFT_UP: begin
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_addr_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (remain_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_ptr_ff;
               wr_addr_in      = rd_ptr_ff + skvt_pkg::IDX_W'(1);
               rd_ptr_in       = rd_ptr_ff - skvt_pkg::IDX_W'(1);
               remain_in       = remain_ff - skvt_pkg::CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ram_req.wr_en         = 1'b1;
                  ram_req.wr_addr       = lo_ff[skvt_pkg::IDX_W-1:0];
                  ram_req.wr_data.key   = key_ff;
                  ram_req.wr_data.value = value_ff;
                  occ_in                = occ_ff + skvt_pkg::CNT_W'(1);
                  resp_go               = 1'b1;
                  resp_status           = skvt_pkg::ST_OK;
                  resp_count            = occ_ff + skvt_pkg::CNT_W'(1);
               end
            end
         end
         SHIFT_DOWN: begin
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_addr_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (remain_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_ptr_ff;
               wr_addr_in      = rd_ptr_ff - skvt_pkg::IDX_W'(1);
               rd_ptr_in       = rd_ptr_ff + skvt_pkg::IDX_W'(1);
               remain_in       = remain_ff - skvt_pkg::CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  occ_in      = occ_m1;
                  resp_go     = 1'b1;
                  resp_status = skvt_pkg::ST_OK;
                  resp_found  = found_ff;
                  resp_count  = occ_m1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (resp_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = resp_status;
         rsp_found_in  = resp_found;
         rsp_pos_in    = skvt_pkg::cnt_to_out(lo_ff);
         rsp_count_in  = skvt_pkg::cnt_to_out(resp_count);
         state_in      = IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      remain_ff     <= remain_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != IDLE);
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY))
      else $error("occupancy above capacity");

   a_write_in_shift: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (state_ff == SHIFT_UP || state_ff == SHIFT_DOWN))
      else $error("store written outside a shift");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("result strobe while busy");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> rsp_valid_ff)
      else $error("occupancy changed without a result");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");
`endif

endmodule

// File: src/sorted_key_value_table_top.sv
// Top level of the sorted key/value table: sequencer and entry store.
//
//  channel   ports                                        beat taken when
//  request   start, busy, req_command, req_key, req_value start && !busy
//  result    rsp_strobe, rsp_status, rsp_found_value,     rsp_strobe (one cycle)
//            rsp_position, rsp_entry_count
//
// Each request runs a binary search of up to log2(CAPACITY)+1 probes and a hit check;
// an insert then shifts the occupancy-position entries from its position up by one,
// and a delete shifts the entries after the removed one down by one; a lookup or a
// refused request does neither. The shift moves one entry per cycle over the single
// write port of the entry store; the search is bound by its read latency.
// Reset clears the count and control; the store is not cleared.
// The result receiver cannot stall; busy holds off requests.
module sorted_key_value_table_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [skvt_pkg::KEY_W-1:0] req_key,
   input  logic [skvt_pkg::VAL_W-1:0] req_value,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [skvt_pkg::VAL_W-1:0] rsp_found_value,
   output logic [skvt_pkg::OUT_W-1:0] rsp_position,
   output logic [skvt_pkg::OUT_W-1:0] rsp_entry_count
);

   skvt_pkg::ram_req_type ram_req;
   skvt_pkg::entry_type   ram_rd_data;

   skvt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_value       (req_value),
      .ram_req         (ram_req),
      .ram_rd_data     (ram_rd_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

   skvt_ram #(
      .WIDTH ($bits(skvt_pkg::entry_type)),
      .DEPTH (skvt_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
